// File: rtl/core/rotational_sweep_point_generator_assert.svh
// assertion helpers, clocked on clk and held off while rst is high
`ifndef ROTATIONAL_SWEEP_POINT_GENERATOR_ASSERT_SVH
`define ROTATIONAL_SWEEP_POINT_GENERATOR_ASSERT_SVH

// same-cycle implication
`define RSPG_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define RSPG_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/core/rspg_pkg.sv
package rspg_pkg;

  localparam int PORT_W     = 32;
  localparam int IDX_W      = 16;
  localparam int RING_W     = 6;
  localparam int ANGLE_W    = 16;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] REG_TOTAL_ANGLE = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_STEPS       = 1'b1;

  localparam logic [ANGLE_W-1:0] ANGLE_RESET = 16'd36000;
  localparam logic [RING_W-1:0]  STEPS_RESET = 6'd12;

  // hundredths of a degree in one full turn
  localparam int ANGLE_TURN = 36000;

  localparam int PHASE_W     = 32;
  localparam int GUARD       = 4;
  localparam int ITERS       = 28;
  localparam int GAIN_W      = 27;
  localparam int ROUND_SHIFT = 27 + GUARD;

  localparam logic [GAIN_W-1:0] GAIN_Q27 = 27'd81504109;

  // arctan(2^-i) with one full turn = 2^32
  localparam logic [PHASE_W-1:0] ATAN_TURN [ITERS] = '{
    32'h20000000, 32'h12E4051D, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
    32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2E,
    32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2F9,
    32'h0000517C, 32'h000028BE, 32'h0000145F, 32'h00000A2F, 32'h00000517,
    32'h0000028B, 32'h00000145, 32'h000000A2, 32'h00000051, 32'h00000028,
    32'h00000014, 32'h0000000A, 32'h00000005
  };

  // side data that rides along with each rotated word
  typedef struct packed {
    logic [IDX_W-1:0]         idx;
    logic [RING_W-1:0]        ring;
    logic                     last;
    logic                     bypass;
    logic signed [PORT_W-1:0] x;
    logic signed [PORT_W-1:0] y;
    logic [PORT_W-1:0]        z;
  } tag_t;

endpackage

// File: rtl/core/rotational_sweep_point_generator.sv
// Each accepted point word yields steps+1 result words, one per cycle while
// out_stall is low: ring 0 is the point as given, ring k is the point turned
// about z by k*total_angle/steps (angle in hundredths of a degree), z unchanged,
// x and y saturated to the coordinate range; a point with x = y = 0 is copied on
// every ring. The ring sequencer issues one rotated copy per cycle, unless
// out_stall holds the pipeline, into a 28-iteration CORDIC pipeline followed by
// a four-stage gain correction, and a point holds the input until its last ring
// is issued. After reset and after every register write a bit-serial divider
// works out the per-ring phase increment, and no point is taken while it runs.
// A steps value of 0 acts as 1, and one above MAX_STEPS acts as MAX_STEPS.
`include "rotational_sweep_point_generator_assert.svh"

module rotational_sweep_point_generator #(
  parameter int MAX_STEPS   = 63,
  parameter int COORD_WIDTH = 32
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_write,
  input  logic [rspg_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [rspg_pkg::CFG_DATA_W-1:0]      cfg_data,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic [rspg_pkg::IDX_W-1:0]           point_index,
  input  logic signed [rspg_pkg::PORT_W-1:0]   x_coord,
  input  logic signed [rspg_pkg::PORT_W-1:0]   y_coord,
  input  logic signed [rspg_pkg::PORT_W-1:0]   z_coord,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic [rspg_pkg::IDX_W-1:0]           out_index,
  output logic [rspg_pkg::RING_W-1:0]          ring,
  output logic signed [rspg_pkg::PORT_W-1:0]   out_x,
  output logic signed [rspg_pkg::PORT_W-1:0]   out_y,
  output logic signed [rspg_pkg::PORT_W-1:0]   out_z,
  output logic                                 last
);
  import rspg_pkg::*;

  localparam int CW       = (COORD_WIDTH < PORT_W) ? COORD_WIDTH : PORT_W;
  localparam int AW       = CW + GUARD + 3;
  localparam int DW       = $clog2(ANGLE_TURN * MAX_STEPS + 1);
  localparam int DIV_BITS = ANGLE_W + PHASE_W;
  localparam int DCNT_W   = $clog2(DIV_BITS);
  localparam int AIDX_W   = $clog2(ANGLE_W);
  localparam int ML_W     = 20;
  localparam int MH_W     = AW - ML_W;
  localparam int PW       = AW + GAIN_W + 1;
  localparam int RW       = PW - ROUND_SHIFT;

  // configuration
  logic [ANGLE_W-1:0] total_angle;
  logic [RING_W-1:0]  steps;
  logic [RING_W-1:0]  n_calc;
  logic [RING_W-1:0]  n_eff;
  logic [DW-1:0]      d_val;

  // phase increment divider
  logic               div_start;
  logic               div_busy;
  logic [DCNT_W-1:0]  div_cnt;
  logic [DW-1:0]      div_rem;
  logic [DW-1:0]      div_rem_next;
  logic [DW:0]        div_t;
  logic               div_bit;
  logic               div_ge;
  logic [PHASE_W-1:0] step_q;

  // ring sequencer
  logic               busy;
  logic               active;
  logic               issue;
  logic               last_issue;
  logic               accept;
  logic [RING_W-1:0]  ring_cnt;
  logic [IDX_W-1:0]   pt_idx;
  logic signed [PORT_W-1:0] pt_x;
  logic signed [PORT_W-1:0] pt_y;
  logic [PORT_W-1:0]  pt_z;
  logic               on_axis;
  logic signed [CW-1:0] x_cw;
  logic signed [CW-1:0] y_cw;
  logic [PHASE_W-1:0] acc_q;
  logic [PHASE_W-1:0] acc_q_next;
  logic [DW-1:0]      acc_r;
  logic [DW-1:0]      acc_r_next;
  logic [DW:0]        acc_sum;
  logic               acc_carry;
  tag_t               issue_tag;

  // pipeline
  logic               pipe_en;
  logic               iv;
  tag_t               it_tag;
  logic [PHASE_W-1:0] it_phase;
  logic               cor_valid;
  logic signed [AW-1:0] cor_a;
  logic signed [AW-1:0] cor_b;
  tag_t               cor_tag;

  logic               v1, v2, v3;
  tag_t               tag_f1, tag_f2, tag_f3;
  logic               neg_a1, neg_b1, neg_a2, neg_b2, neg_a3, neg_b3;
  logic [AW-1:0]      mag_a, mag_b;
  logic [ML_W+GAIN_W-1:0] pl_a, pl_b;
  logic [MH_W+GAIN_W-1:0] ph_a, ph_b;
  logic [PW-1:0]      sum_a, sum_b;
  logic [RW-1:0]      r_a, r_b;

  function automatic logic signed [PORT_W-1:0] sat_out(input logic neg,
                                                       input logic [RW-1:0] r);
    logic [RW-1:0]      maxv;
    logic signed [CW-1:0] v;
    maxv = (RW'(1) << (CW - 1)) - RW'(1);
    if (r > maxv) begin
      v = neg ? {1'b1, {(CW-1){1'b0}}} : {1'b0, {(CW-1){1'b1}}};
    end else begin
      v = neg ? -CW'(r) : CW'(r);
    end
    return PORT_W'(v);
  endfunction

  // ---------------------------------------------------------------- config
  always_ff @(posedge clk) begin
    if (rst) begin
      total_angle <= ANGLE_RESET;
      steps       <= STEPS_RESET;
      div_start   <= 1'b1;
    end else begin
      div_start <= cfg_write;
      if (cfg_write) begin
        unique case (cfg_index)
          REG_TOTAL_ANGLE: total_angle <= cfg_data[ANGLE_W-1:0];
          REG_STEPS:       steps       <= cfg_data[RING_W-1:0];
          default:         ;
        endcase
      end
    end
  end

  always_comb begin
    if (steps == '0) begin
      n_calc = RING_W'(1);
    end else if (steps > RING_W'(MAX_STEPS)) begin
      n_calc = RING_W'(MAX_STEPS);
    end else begin
      n_calc = steps;
    end
  end

  always_ff @(posedge clk) begin
    n_eff <= n_calc;
    d_val <= DW'(n_calc) * DW'(ANGLE_TURN);
  end

  // ---------------------------------------------------------------- divider
  // total_angle * 2^32 / d, one quotient bit a cycle; low 32 bits kept
  assign div_bit = (div_cnt < DCNT_W'(ANGLE_W)) ?
                   total_angle[AIDX_W'(ANGLE_W - 1) - div_cnt[AIDX_W-1:0]] : 1'b0;
  assign div_t        = {div_rem, div_bit};
  assign div_ge       = div_t >= {1'b0, d_val};
  assign div_rem_next = div_ge ? DW'(div_t - {1'b0, d_val}) : DW'(div_t);

  always_ff @(posedge clk) begin
    if (rst) begin
      div_busy <= 1'b0;
      div_cnt  <= '0;
    end else if (div_start) begin
      div_busy <= 1'b1;
      div_cnt  <= '0;
    end else if (div_busy) begin
      if (div_cnt == DCNT_W'(DIV_BITS - 1)) begin
        div_busy <= 1'b0;
      end
      div_cnt <= div_cnt + DCNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (div_start) begin
      div_rem <= '0;
      step_q  <= '0;
    end else if (div_busy) begin
      div_rem <= div_rem_next;
      step_q  <= {step_q[PHASE_W-2:0], div_ge};
    end
  end

  // ---------------------------------------------------------------- sequencer
  assign pipe_en    = !(out_valid && out_stall);
  assign busy       = div_start || div_busy;
  assign issue      = active && pipe_en;
  assign last_issue = issue && (ring_cnt == n_eff);
  assign in_stall   = busy || (active && !last_issue);
  assign accept     = in_valid && !in_stall;

  assign x_cw = x_coord[CW-1:0];
  assign y_cw = y_coord[CW-1:0];

  // phase of ring k+1 from ring k: quotient and remainder step together
  assign acc_sum    = {1'b0, acc_r} + {1'b0, div_rem};
  assign acc_carry  = acc_sum >= {1'b0, d_val};
  assign acc_r_next = acc_carry ? DW'(acc_sum - {1'b0, d_val}) : DW'(acc_sum);
  assign acc_q_next = acc_q + step_q + PHASE_W'(acc_carry);

  always_ff @(posedge clk) begin
    if (rst) begin
      active   <= 1'b0;
      ring_cnt <= '0;
    end else if (accept) begin
      active   <= 1'b1;
      ring_cnt <= '0;
    end else if (last_issue) begin
      active <= 1'b0;
    end else if (issue) begin
      ring_cnt <= ring_cnt + RING_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      pt_idx  <= point_index;
      pt_x    <= PORT_W'(x_cw);
      pt_y    <= PORT_W'(y_cw);
      pt_z    <= z_coord;
      on_axis <= (x_cw == '0) && (y_cw == '0);
      acc_q   <= '0;
      acc_r   <= d_val >> 1;
    end else if (issue) begin
      acc_q <= acc_q_next;
      acc_r <= acc_r_next;
    end
  end

  always_comb begin
    issue_tag.idx    = pt_idx;
    issue_tag.ring   = ring_cnt;
    issue_tag.last   = (ring_cnt == n_eff);
    issue_tag.bypass = (ring_cnt == '0) || on_axis;
    issue_tag.x      = pt_x;
    issue_tag.y      = pt_y;
    issue_tag.z      = pt_z;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      iv <= 1'b0;
    end else if (pipe_en) begin
      iv <= issue;
    end
  end

  always_ff @(posedge clk) begin
    if (pipe_en) begin
      it_tag   <= issue_tag;
      it_phase <= acc_q;
    end
  end

  rspg_cordic #(
    .AW (AW)
  ) u_cordic (
    .clk       (clk),
    .rst       (rst),
    .en        (pipe_en),
    .in_valid  (iv),
    .phase     (it_phase),
    .in_tag    (it_tag),
    .out_valid (cor_valid),
    .out_a     (cor_a),
    .out_b     (cor_b),
    .out_tag   (cor_tag)
  );

  // ---------------------------------------------------------------- gain correction
  assign sum_a = (PW'(ph_a) << ML_W) + PW'(pl_a) + (PW'(1) << (ROUND_SHIFT - 1));
  assign sum_b = (PW'(ph_b) << ML_W) + PW'(pl_b) + (PW'(1) << (ROUND_SHIFT - 1));

  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      v2        <= 1'b0;
      v3        <= 1'b0;
      out_valid <= 1'b0;
    end else if (pipe_en) begin
      v1        <= cor_valid;
      v2        <= v1;
      v3        <= v2;
      out_valid <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (pipe_en) begin
      // magnitude
      tag_f1 <= cor_tag;
      neg_a1 <= cor_a[AW-1];
      neg_b1 <= cor_b[AW-1];
      mag_a  <= cor_a[AW-1] ? -cor_a : cor_a;
      mag_b  <= cor_b[AW-1] ? -cor_b : cor_b;
      // partial products
      tag_f2 <= tag_f1;
      neg_a2 <= neg_a1;
      neg_b2 <= neg_b1;
      pl_a   <= mag_a[ML_W-1:0] * GAIN_Q27;
      pl_b   <= mag_b[ML_W-1:0] * GAIN_Q27;
      ph_a   <= mag_a[AW-1:ML_W] * GAIN_Q27;
      ph_b   <= mag_b[AW-1:ML_W] * GAIN_Q27;
      // sum and round
      tag_f3 <= tag_f2;
      neg_a3 <= neg_a2;
      neg_b3 <= neg_b2;
      r_a    <= sum_a[PW-1:ROUND_SHIFT];
      r_b    <= sum_b[PW-1:ROUND_SHIFT];
      // saturate and drive the output word
      out_index <= tag_f3.idx;
      ring      <= tag_f3.ring;
      last      <= tag_f3.last;
      out_z     <= tag_f3.z;
      out_x     <= tag_f3.bypass ? tag_f3.x : sat_out(neg_a3, r_a);
      out_y     <= tag_f3.bypass ? tag_f3.y : sat_out(neg_b3, r_b);
    end
  end

  // ---------------------------------------------------------------- checks
  `RSPG_ASSERT_NEXT(a_accept_starts_ring0, in_valid && !in_stall, active && ring_cnt == '0, "accepted point did not start at ring 0")
  `RSPG_ASSERT_SAME(a_stall_mid_point, active && ring_cnt != n_eff, in_stall, "input open before the last ring was issued")
  `RSPG_ASSERT_NEXT(a_ring_advance, issue && ring_cnt != n_eff, ring_cnt == $past(ring_cnt) + RING_W'(1), "ring counter skipped or repeated")

endmodule

// File: rtl/core/rspg_cordic.sv
module rspg_cordic #(
  parameter int AW = 39
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         en,
  input  logic                         in_valid,
  input  logic [rspg_pkg::PHASE_W-1:0] phase,
  input  rspg_pkg::tag_t               in_tag,
  output logic                         out_valid,
  output logic signed [AW-1:0]         out_a,
  output logic signed [AW-1:0]         out_b,
  output rspg_pkg::tag_t               out_tag
);
  import rspg_pkg::*;

  localparam logic [1:0] QUAD_0 = 2'd0;
  localparam logic [1:0] QUAD_1 = 2'd1;
  localparam logic [1:0] QUAD_2 = 2'd2;
  localparam logic [1:0] QUAD_3 = 2'd3;

  logic signed [AW-1:0]      xa, ya, qa, qb;
  logic signed [AW-1:0]      a_s [ITERS+1];
  logic signed [AW-1:0]      b_s [ITERS+1];
  logic signed [PHASE_W-1:0] z_s [ITERS+1];
  tag_t                      tag_s [ITERS+1];
  logic                      v_s [ITERS+1];

  // quarter turns are exact swaps and negations
  always_comb begin
    xa = AW'(in_tag.x);
    ya = AW'(in_tag.y);
    unique case (phase[PHASE_W-1 -: 2])
      QUAD_0: begin
        qa = xa;
        qb = ya;
      end
      QUAD_1: begin
        qa = -ya;
        qb = xa;
      end
      QUAD_2: begin
        qa = -xa;
        qb = -ya;
      end
      QUAD_3: begin
        qa = ya;
        qb = -xa;
      end
      default: begin
        qa = xa;
        qb = ya;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v_s[0] <= 1'b0;
    end else if (en) begin
      v_s[0] <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_s[0]   <= qa <<< GUARD;
      b_s[0]   <= qb <<< GUARD;
      z_s[0]   <= {2'b00, phase[PHASE_W-3:0]};
      tag_s[0] <= in_tag;
    end
  end

  for (genvar i = 0; i < ITERS; i++) begin : g_iter
    always_ff @(posedge clk) begin
      if (rst) begin
        v_s[i+1] <= 1'b0;
      end else if (en) begin
        v_s[i+1] <= v_s[i];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        tag_s[i+1] <= tag_s[i];
        if (!z_s[i][PHASE_W-1]) begin
          a_s[i+1] <= a_s[i] - (b_s[i] >>> i);
          b_s[i+1] <= b_s[i] + (a_s[i] >>> i);
          z_s[i+1] <= z_s[i] - $signed(ATAN_TURN[i]);
        end else begin
          a_s[i+1] <= a_s[i] + (b_s[i] >>> i);
          b_s[i+1] <= b_s[i] - (a_s[i] >>> i);
          z_s[i+1] <= z_s[i] + $signed(ATAN_TURN[i]);
        end
      end
    end
  end

  assign out_valid = v_s[ITERS];
  assign out_a     = a_s[ITERS];
  assign out_b     = b_s[ITERS];
  assign out_tag   = tag_s[ITERS];

endmodule

// File: test/tb_top.sv
module tb_top;

  localparam int WATCHDOG_LIMIT = 6000;
  localparam int LONG_HOLD      = 400;
  localparam int MAX_RING       = 63;

  // arctan(2^-i), one full turn = 2^32
  localparam logic [31:0] ARCTAN_TURN [28] = '{
    32'h20000000, 32'h12E4051D, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
    32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2E,
    32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2F9,
    32'h0000517C, 32'h000028BE, 32'h0000145F, 32'h00000A2F, 32'h00000517,
    32'h0000028B, 32'h00000145, 32'h000000A2, 32'h00000051, 32'h00000028,
    32'h00000014, 32'h0000000A, 32'h00000005
  };

  typedef struct packed {
    logic [15:0] idx;
    logic [5:0]  ring;
    logic [31:0] x;
    logic [31:0] y;
    logic [31:0] z;
    logic        last;
  } ring_word_t;

  class sweep_scoreboard;
    logic [15:0]  angle_reg;
    logic [5:0]   steps_reg;
    ring_word_t   expected_rings[$];
    int unsigned  errors;

    function new();
      angle_reg = 16'd36000;
      steps_reg = 6'd12;
      errors    = 0;
    endfunction

    function void set_reg(logic [rspg_pkg::CFG_IDX_W-1:0] index, logic [15:0] data);
      if (index == rspg_pkg::REG_TOTAL_ANGLE) angle_reg = data;
      else if (index == rspg_pkg::REG_STEPS) steps_reg = data[5:0];
    endfunction

    function int unsigned pending();
      return expected_rings.size();
    endfunction

    // gain correction, magnitude rounded half away from zero, then saturated
    function logic [31:0] apply_gain(longint v);
      logic [63:0] mag;
      logic [63:0] r;
      mag = (v < 0) ? 64'(-v) : 64'(v);
      r = (mag * 64'd81504109 + (64'd1 << 30)) >> 31;
      if (r > 64'h7FFFFFFF) return (v < 0) ? 32'h80000000 : 32'h7FFFFFFF;
      return (v < 0) ? -r[31:0] : r[31:0];
    endfunction

    function void turn_point(input logic signed [31:0] x, input logic signed [31:0] y,
                             input logic [31:0] phase,
                             output logic [31:0] rx, output logic [31:0] ry);
      longint a, b, za, da, db;
      int i;
      case (phase[31:30])
        2'd1: begin a = -longint'(y); b = x; end
        2'd2: begin a = -longint'(x); b = -longint'(y); end
        2'd3: begin a = y; b = -longint'(x); end
        default: begin a = x; b = y; end
      endcase
      a = a * 16;
      b = b * 16;
      za = {34'd0, phase[29:0]};
      for (i = 0; i < 28; i++) begin
        da = b >>> i;
        db = a >>> i;
        if (za >= 0) begin
          a = a - da;
          b = b + db;
          za = za - longint'({32'd0, ARCTAN_TURN[i]});
        end else begin
          a = a + da;
          b = b - db;
          za = za + longint'({32'd0, ARCTAN_TURN[i]});
        end
      end
      rx = apply_gain(a);
      ry = apply_gain(b);
    endfunction

    function void predict_rings(logic [15:0] idx, logic signed [31:0] x,
                                logic signed [31:0] y, logic [31:0] z);
      int unsigned n, k;
      logic [63:0] den, num;
      logic [31:0] phase;
      ring_word_t w;
      n = (steps_reg == 0) ? 1 : steps_reg;
      if (n > MAX_RING) n = MAX_RING;
      den = 64'd36000 * 64'(n);
      for (k = 0; k <= n; k++) begin
        w.idx  = idx;
        w.ring = k[5:0];
        w.x    = x;
        w.y    = y;
        w.z    = z;
        w.last = (k == n);
        // a point on the axis is copied on every ring
        if (k != 0 && (x != 0 || y != 0)) begin
          num = (64'(k) * 64'(angle_reg)) << 32;
          phase = 32'((num + den / 2) / den);
          turn_point(x, y, phase, w.x, w.y);
        end
        expected_rings.push_back(w);
      end
    endfunction

    function void check_result(logic [15:0] idx, logic [5:0] rg, logic [31:0] x,
                               logic [31:0] y, logic [31:0] z, logic lst);
      ring_word_t w;
      if (expected_rings.size() == 0) begin
        $error("result word with none expected: out_index %0d ring %0d", idx, rg);
        errors++;
        return;
      end
      w = expected_rings.pop_front();
      if (idx !== w.idx) begin
        $error("out_index: expected %0d, got %0d", w.idx, idx);
        errors++;
      end
      if (rg !== w.ring) begin
        $error("ring: expected %0d, got %0d", w.ring, rg);
        errors++;
      end
      if (x !== w.x) begin
        $error("out_x: expected %0d, got %0d", $signed(w.x), $signed(x));
        errors++;
      end
      if (y !== w.y) begin
        $error("out_y: expected %0d, got %0d", $signed(w.y), $signed(y));
        errors++;
      end
      if (z !== w.z) begin
        $error("out_z: expected %0d, got %0d", $signed(w.z), $signed(z));
        errors++;
      end
      if (lst !== w.last) begin
        $error("last: expected %0d, got %0d", w.last, lst);
        errors++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst;
  logic cfg_write;
  logic [rspg_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [rspg_pkg::CFG_DATA_W-1:0] cfg_data;
  logic in_valid;
  logic in_stall;
  logic [rspg_pkg::IDX_W-1:0] point_index;
  logic signed [rspg_pkg::PORT_W-1:0] x_coord;
  logic signed [rspg_pkg::PORT_W-1:0] y_coord;
  logic signed [rspg_pkg::PORT_W-1:0] z_coord;
  logic out_valid;
  logic out_stall;
  logic [rspg_pkg::IDX_W-1:0] out_index;
  logic [rspg_pkg::RING_W-1:0] ring;
  logic signed [rspg_pkg::PORT_W-1:0] out_x;
  logic signed [rspg_pkg::PORT_W-1:0] out_y;
  logic signed [rspg_pkg::PORT_W-1:0] out_z;
  logic last;

  sweep_scoreboard sb;

  logic        tx_calm = 1'b0;
  logic        tx_rush = 1'b0;
  logic        rx_calm = 1'b0;
  logic        rx_hold_req = 1'b0;
  int unsigned rx_gap = 0;
  int unsigned quiet_cycles = 0;

  rotational_sweep_point_generator i_dut (
    .clk         (clk),
    .rst         (rst),
    .cfg_write   (cfg_write),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .point_index (point_index),
    .x_coord     (x_coord),
    .y_coord     (y_coord),
    .z_coord     (z_coord),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_index   (out_index),
    .ring        (ring),
    .out_x       (out_x),
    .out_y       (out_y),
    .out_z       (out_z),
    .last        (last)
  );

  always #5 clk = ~clk;

  // result side: stall pattern, long hold-off on request
  initial begin : result_sink
    int unsigned hold_left;
    hold_left = 0;
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (rx_hold_req) begin
        hold_left = LONG_HOLD;
        rx_hold_req = 1'b0;
      end
      if (hold_left != 0) begin
        out_stall <= 1'b1;
        hold_left--;
      end else if (rx_gap != 0) begin
        out_stall <= 1'b1;
        rx_gap--;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid === 1'b1 && out_stall == 1'b0) begin
      sb.check_result(out_index, ring, out_x, out_y, out_z, last);
      if ($urandom_range(0, 59) == 0) rx_calm = !rx_calm;
      rx_gap = rx_calm ? 0 : $urandom_range(0, 17);
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles = 0;
    else quiet_cycles++;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("[rotational_sweep_point_generator] ERROR");
      $finish;
    end
  end

  task automatic write_reg(input logic [rspg_pkg::CFG_IDX_W-1:0] index,
                           input logic [15:0] data);
    @(negedge clk);
    cfg_write <= 1'b1;
    cfg_index <= index;
    cfg_data  <= data;
    sb.set_reg(index, data);
    @(negedge clk);
    cfg_write <= 1'b0;
  endtask

  task automatic send_point(input logic [15:0] idx, input logic [31:0] x,
                            input logic [31:0] y, input logic [31:0] z);
    int unsigned gap;
    if ($urandom_range(0, 29) == 0) tx_calm = !tx_calm;
    gap = (tx_calm || tx_rush) ? 0 : $urandom_range(0, 17);
    @(negedge clk);
    repeat (gap) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid    <= 1'b1;
    point_index <= idx;
    x_coord     <= x;
    y_coord     <= y;
    z_coord     <= z;
    do @(posedge clk); while (in_stall !== 1'b0);
    sb.predict_rings(idx, x, y, z);
  endtask

  task automatic tx_quiet();
    @(negedge clk);
    in_valid <= 1'b0;
  endtask

  task automatic wait_drained();
    while (sb.pending() != 0) @(posedge clk);
  endtask

  function automatic logic [31:0] pick_coord();
    case ($urandom_range(0, 7))
      0: begin
        case ($urandom_range(0, 4))
          0: return 32'h7FFFFFFF;
          1: return 32'h80000000;
          2: return 32'h00000001;
          3: return 32'hFFFFFFFF;
          default: return 32'h00000000;
        endcase
      end
      1, 2: return $urandom_range(0, 32'h3FFFF) - 32'h20000;
      3: return 32'h00000000;
      default: return $urandom;
    endcase
  endfunction

  task automatic run_batch(input int count);
    logic [31:0] x, y;
    int i;
    for (i = 0; i < count; i++) begin
      x = pick_coord();
      y = pick_coord();
      if ($urandom_range(0, 9) == 0) begin
        x = 0;
        y = 0;
      end
      send_point($urandom_range(0, 65535), x, y, $urandom);
    end
    tx_quiet();
  endtask

  task automatic special_phase(input logic [15:0] angle, input logic [15:0] steps_word);
    write_reg(rspg_pkg::REG_TOTAL_ANGLE, angle);
    write_reg(rspg_pkg::REG_STEPS, steps_word);
    run_batch(2);
    wait_drained();
  endtask

  task automatic random_settings();
    logic [15:0] angle;
    logic [5:0]  st;
    logic [9:0]  hi;
    int unsigned r;
    r = $urandom_range(0, 9);
    if (r == 0) angle = 16'd0;
    else if (r == 1) angle = 16'd36000;
    else if (r == 2) angle = 16'hFFFF;
    else if (r < 5) angle = $urandom_range(0, 65535);
    else angle = $urandom_range(0, 36000);
    r = $urandom_range(0, 19);
    if (r == 0) st = 6'd0;
    else if (r == 1) st = 6'd63;
    else st = $urandom_range(1, 16);
    hi = $urandom_range(0, 1023);
    if ($urandom_range(0, 3) != 0) write_reg(rspg_pkg::REG_TOTAL_ANGLE, angle);
    if ($urandom_range(0, 3) != 0) write_reg(rspg_pkg::REG_STEPS, {hi, st});
  endtask

  initial begin : stimulus
    int ph;
    sb = new();
    rst         = 1'b1;
    cfg_write   = 1'b0;
    cfg_index   = '0;
    cfg_data    = '0;
    in_valid    = 1'b0;
    point_index = '0;
    x_coord     = '0;
    y_coord     = '0;
    z_coord     = '0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // reset settings: axis points, unit vectors, corners, bit patterns
    send_point(16'h0000, 32'h00000000, 32'h00000000, 32'h7FFFFFFF);
    send_point(16'hFFFF, 32'h00000000, 32'h00000000, 32'h80000000);
    send_point(16'd1, 32'h00010000, 32'h00000000, 32'h00000000);
    send_point(16'd2, 32'h00000000, 32'h00010000, 32'h00010000);
    send_point(16'd3, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'hFFFFFFFF);
    send_point(16'd4, 32'h80000000, 32'h80000000, 32'h00000000);
    send_point(16'd5, 32'h7FFFFFFF, 32'h80000000, 32'h12345678);
    send_point(16'd6, 32'h80000000, 32'h7FFFFFFF, 32'h87654321);
    send_point(16'd7, 32'h00000001, 32'h00000000, 32'h00000001);
    send_point(16'd8, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF);
    send_point(16'd9, 32'h00000000, 32'h80000000, 32'h00000000);
    send_point(16'd10, 32'h80000000, 32'h00000000, 32'h00000000);
    send_point(16'h5555, 32'h55555555, 32'hAAAAAAAA, 32'h5555AAAA);
    send_point(16'hAAAA, 32'hAAAAAAAA, 32'h55555555, 32'hAAAA5555);
    tx_quiet();
    wait_drained();

    special_phase(16'd0, 16'h0001);      // no turn at all, single step
    special_phase(16'hFFFF, 16'h003F);   // past a full turn, most steps
    special_phase(16'd18000, 16'hFFC0);  // steps of zero act as one
    special_phase(16'd36000, 16'h0004);  // exact quarter turns
    special_phase(16'd9000, 16'h0001);

    for (ph = 0; ph < 12; ph++) begin
      random_settings();
      if (ph == 2) begin
        // receiver holds off while words keep coming, block backs up
        tx_rush = 1'b1;
        rx_hold_req = 1'b1;
        run_batch(33);
        tx_rush = 1'b0;
      end else if (ph == 5) begin
        run_batch(16);
        wait_drained();
        run_batch(17);
      end else begin
        run_batch(33);
      end
      wait_drained();
    end

    repeat (80) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("[rotational_sweep_point_generator] OK");
    end else begin
      $display("[rotational_sweep_point_generator] ERROR");
    end
    $finish;
  end

endmodule

// File: sim.f
+incdir+rtl/core
rtl/core/rspg_pkg.sv
rtl/core/rspg_cordic.sv
rtl/core/rotational_sweep_point_generator.sv
test/tb_top.sv
